// File: rtl/core/pmt_pkg.sv
// Shared types and constants for the pending request match table.
package pmt_pkg;

	// Operation codes carried in the kind field
	localparam logic [2:0] KIND_TICK       = 3'd0;
	localparam logic [2:0] KIND_ADD        = 3'd1;
	localparam logic [2:0] KIND_FIND       = 3'd2;
	localparam logic [2:0] KIND_FIND_SINCE = 3'd3;
	localparam logic [2:0] KIND_PURGE      = 3'd4;

	// Command beat
	typedef struct packed {
		logic [2:0]  kind;
		logic [15:0] service;
		logic [15:0] subtype;
		logic [31:0] request_id;
		logic [31:0] since_time;
		logic [31:0] age_limit;
	} in_t;

	// Result beat
	typedef struct packed {
		logic        found;
		logic [15:0] match_service;
		logic [15:0] match_subtype;
		logic [31:0] match_request;
		logic [6:0]  removed_count;
		logic        table_full;
	} out_t;

	// One stored request
	typedef struct packed {
		logic [15:0] service;
		logic [15:0] subtype;
		logic [31:0] request;
		logic [31:0] stamp;
	} entry_t;

	// Controls broadcast to every cell
	typedef struct packed {
		logic add;
		logic eval_find;
		logic use_since;
		logic eval_purge;
		logic compact;
	} cell_ctl_t;

endpackage

// File: rtl/core/pmt_cell.sv
// One table slot: holds an entry, matches it against the query, shifts down on compaction.
module pmt_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  pmt_pkg::cell_ctl_t ctl,
	input  pmt_pkg::in_t       query,
	input  logic [31:0]        now,
	input  logic               prev_valid,
	input  pmt_pkg::entry_t    next_entry,
	input  logic               next_valid,
	input  logic               next_dead,
	input  logic               hit_below_in,
	output logic               hit_below_out,
	input  logic               dead_below_in,
	output logic               dead_below_out,
	output pmt_pkg::entry_t    entry,
	output logic               valid,
	output logic               dead,
	output logic               first
);

	pmt_pkg::entry_t entry_q;
	logic            valid_q;
	logic            dead_q;
	logic            svc_ok;
	logic            sub_ok;
	logic            req_ok;
	logic            since_ok;
	logic            hit;
	logic            stale;
	logic            take_new;
	logic            shift;
	logic [31:0]     age;

	// Query match; stored service 0 matches anything
	always_comb begin
		svc_ok   = (entry_q.service == query.service) || (entry_q.service == 16'd0);
		sub_ok   = (query.subtype == 16'd0) || (entry_q.subtype == query.subtype);
		req_ok   = (query.request_id == 32'd0) || (entry_q.request == query.request_id);
		since_ok = !ctl.use_since || (entry_q.stamp >= query.since_time);
		hit      = valid_q && svc_ok && sub_ok && req_ok && since_ok;
		first    = ctl.eval_find && hit && !hit_below_in;
		age      = now - entry_q.stamp;
		stale    = valid_q && (age >= query.age_limit);
	end

	assign hit_below_out  = hit_below_in | hit;
	assign dead_below_out = dead_below_in | dead_q;
	// shift down once a removed slot sits at or below this one
	assign shift          = ctl.compact && (dead_below_in || dead_q);
	// first empty slot takes a new entry
	assign take_new       = ctl.add && !valid_q && prev_valid;

	// Slot control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			dead_q  <= 1'b0;
		end else if (shift) begin
			valid_q <= next_valid;
			dead_q  <= next_dead;
		end else if (take_new) begin
			valid_q <= 1'b1;
		end else if (ctl.eval_find) begin
			dead_q <= first;
		end else if (ctl.eval_purge) begin
			dead_q <= stale;
		end
	end

	// Slot payload
	always_ff @(posedge clk) begin
		if (shift) begin
			entry_q <= next_entry;
		end else if (take_new) begin
			entry_q.service <= query.service;
			entry_q.subtype <= query.subtype;
			entry_q.request <= query.request_id;
			entry_q.stamp   <= now;
		end
	end

	assign entry = entry_q;
	assign valid = valid_q;
	assign dead  = dead_q;

endmodule

// File: rtl/core/pending_request_match_table.sv
// Top level: ordered request table built as a chain of slot cells.
//
//  channel | ports              | handshake
//  --------+--------------------+-----------------------------------------
//  command | cmd (in_t)         | taken at a clock edge with start and !busy
//  result  | result (out_t)     | one beat per command, valid while done
//
// Tick, add and unused kinds go from the evaluate step straight to done.
// Find without a match passes evaluate, a compaction check and the result,
// and with one the removed slot also needs one compaction step.
// Purge needs one compaction step per removed entry; compaction closes one
// hole per cycle by shifting the cells above it down by one slot.
// Reset empties the table and clears the tick counter; no clearing pass.
// busy is high from the accepted beat until the result beat; the receiver
// cannot stall, so done is a single cycle strobe.
module pending_request_match_table #(
	parameter int TABLE_DEPTH = 64
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  pmt_pkg::in_t  cmd,
	output logic          done,
	output pmt_pkg::out_t result
);

	localparam int OCC_W = $clog2(TABLE_DEPTH + 1);

	typedef enum logic [2:0] {
		ST_IDLE    = 3'b001,
		ST_EVAL    = 3'b010,
		ST_COMPACT = 3'b100
	} state_t;

	state_t             state_q;
	pmt_pkg::in_t       cmd_q;
	pmt_pkg::out_t      res_q;
	pmt_pkg::out_t      res_eval;
	logic               done_q;
	logic [OCC_W-1:0]   occ_q;
	logic [31:0]        now_q;
	pmt_pkg::cell_ctl_t ctl;

	pmt_pkg::entry_t        ent [TABLE_DEPTH];
	logic [TABLE_DEPTH-1:0] valid_vec;
	logic [TABLE_DEPTH-1:0] dead_vec;
	logic [TABLE_DEPTH-1:0] first_vec;
	logic [TABLE_DEPTH:0]   hit_chain;
	logic [TABLE_DEPTH:0]   dead_chain;
	pmt_pkg::entry_t        hit_entry;
	logic                   any_dead;
	logic                   full;
	logic                   is_find;
	logic                   is_purge;

	assign is_find  = (cmd_q.kind == pmt_pkg::KIND_FIND) ||
	                  (cmd_q.kind == pmt_pkg::KIND_FIND_SINCE);
	assign is_purge = (cmd_q.kind == pmt_pkg::KIND_PURGE);
	assign full     = (occ_q == OCC_W'(TABLE_DEPTH));
	assign any_dead = dead_chain[TABLE_DEPTH];

	// Broadcast controls
	always_comb begin
		ctl.add        = (state_q == ST_EVAL) && (cmd_q.kind == pmt_pkg::KIND_ADD);
		ctl.eval_find  = (state_q == ST_EVAL) && is_find;
		ctl.use_since  = (cmd_q.kind == pmt_pkg::KIND_FIND_SINCE);
		ctl.eval_purge = (state_q == ST_EVAL) && is_purge;
		ctl.compact    = (state_q == ST_COMPACT);
	end

	assign hit_chain[0]  = 1'b0;
	assign dead_chain[0] = 1'b0;

	// Cell row, oldest entry in cell 0
	for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
		pmt_pkg::entry_t nxt_entry;
		logic            nxt_valid;
		logic            nxt_dead;
		logic            prv_valid;

		if (i == TABLE_DEPTH - 1) begin : g_top
			assign nxt_entry = '0;
			assign nxt_valid = 1'b0;
			assign nxt_dead  = 1'b0;
		end else begin : g_mid
			assign nxt_entry = ent[i+1];
			assign nxt_valid = valid_vec[i+1];
			assign nxt_dead  = dead_vec[i+1];
		end

		if (i == 0) begin : g_bot
			assign prv_valid = 1'b1;
		end else begin : g_up
			assign prv_valid = valid_vec[i-1];
		end

		pmt_cell u_cell (
			.clk            (clk),
			.arst_n         (arst_n),
			.ctl            (ctl),
			.query          (cmd_q),
			.now            (now_q),
			.prev_valid     (prv_valid),
			.next_entry     (nxt_entry),
			.next_valid     (nxt_valid),
			.next_dead      (nxt_dead),
			.hit_below_in   (hit_chain[i]),
			.hit_below_out  (hit_chain[i+1]),
			.dead_below_in  (dead_chain[i]),
			.dead_below_out (dead_chain[i+1]),
			.entry          (ent[i]),
			.valid          (valid_vec[i]),
			.dead           (dead_vec[i]),
			.first          (first_vec[i])
		);
	end

	// Gather the data of the single first-matching cell
	always_comb begin
		hit_entry = '0;
		for (int i = 0; i < TABLE_DEPTH; i++) begin
			hit_entry = hit_entry | (first_vec[i] ? ent[i] : '0);
		end
	end

	// Result of the evaluate step
	always_comb begin
		res_eval = '0;
		if (cmd_q.kind == pmt_pkg::KIND_ADD) begin
			res_eval.table_full = full;
		end
		if (is_find) begin
			res_eval.found         = |first_vec;
			res_eval.match_service = hit_entry.service;
			res_eval.match_subtype = hit_entry.subtype;
			res_eval.match_request = hit_entry.request;
		end
	end

	// Sequencer, counters and done strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
			occ_q   <= '0;
			now_q   <= '0;
		end else begin
			done_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_EVAL;
					end
				end
				ST_EVAL: begin
					if (is_find || is_purge) begin
						state_q <= ST_COMPACT;
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
					if (cmd_q.kind == pmt_pkg::KIND_TICK) begin
						now_q <= now_q + 32'd1;
					end
					if (cmd_q.kind == pmt_pkg::KIND_ADD && !full) begin
						occ_q <= occ_q + OCC_W'(1);
					end
				end
				ST_COMPACT: begin
					if (any_dead) begin
						occ_q <= occ_q - OCC_W'(1);
					end else begin
						state_q <= ST_IDLE;
						done_q  <= 1'b1;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Command and result payload
	always_ff @(posedge clk) begin
		if (state_q == ST_IDLE && start) begin
			cmd_q <= cmd;
		end
		if (state_q == ST_EVAL) begin
			res_q <= res_eval;
		end else if (state_q == ST_COMPACT && any_dead && is_purge) begin
			res_q.removed_count <= res_q.removed_count + 7'd1;
		end
	end

	assign busy   = (state_q != ST_IDLE);
	assign done   = done_q;
	assign result = res_q;

	// Occupancy tracks the number of filled slots
	a_occ_count: assert property (@(posedge clk) disable iff (!arst_n)
		occ_q == OCC_W'($countones(valid_vec)))
		else $error("occupancy differs from filled slot count");

	// Only filled slots are marked for removal
	a_dead_valid: assert property (@(posedge clk) disable iff (!arst_n)
		(dead_vec & ~valid_vec) == '0)
		else $error("empty slot marked for removal");

	// A find removes at most one entry
	a_find_one: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COMPACT && is_find) |-> ($countones(dead_vec) <= 1))
		else $error("find marked more than one slot");

	// Result beat comes after the work and leaves the block ready
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (!busy && $past(busy)))
		else $error("done strobe while busy");

	// Filled slots stay packed at the bottom of the row
	a_packed: assert property (@(posedge clk) disable iff (!arst_n)
		((valid_vec & (valid_vec + 1'b1)) == '0))
		else $error("gap between filled slots");

endmodule

// File: tb/sv/tb_pending_request_match_table.sv
// Self-checking testbench for the pending request match table: directed and random command beats.
`timescale 1ns / 1ps

module tb_pending_request_match_table;

	localparam int         TABLE_DEPTH = 64;
	localparam logic [2:0] KIND_LAST   = 3'd7;

	logic          clk;
	logic          arst_n;
	logic          start;
	logic          busy;
	pmt_pkg::in_t  cmd;
	logic          done;
	pmt_pkg::out_t result;

	// Shadow copy of the table, updated when a command beat is accepted
	pmt_pkg::entry_t shadow_slots [TABLE_DEPTH];
	int              shadow_count = 0;
	logic [31:0]     shadow_now = '0;

	pmt_pkg::out_t pending_results [$];
	int            mismatches = 0;
	bit            sender_idles = 1'b1;

	pending_request_match_table #(
		.TABLE_DEPTH(TABLE_DEPTH)
	) i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.cmd(cmd),
		.done(done),
		.result(result)
	);

	// 100 MHz clock
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Run limit
	initial begin
		#5_000_000;
		$display("*** FAILED ***");
		$finish;
	end

	// Stored service 0 matches any query; query subtype/request 0 are wildcards
	function automatic bit entry_matches(input pmt_pkg::entry_t e, input pmt_pkg::in_t c);
		return (e.service == c.service || e.service == 16'd0) &&
			(c.subtype == 16'd0 || e.subtype == c.subtype) &&
			(c.request_id == 32'd0 || e.request == c.request_id);
	endfunction

	// Remove one entry and close the hole, keeping order
	function automatic void drop_entry(input int pos);
		for (int j = pos; j < shadow_count - 1; j++)
			shadow_slots[j] = shadow_slots[j + 1];
		shadow_count--;
	endfunction

	// Expected result of one command; updates the shadow table
	function automatic pmt_pkg::out_t table_outcome(input pmt_pkg::in_t c);
		pmt_pkg::out_t o;
		int            hit;
		int            k;
		o   = '0;
		hit = -1;
		case (c.kind)
			pmt_pkg::KIND_TICK: begin
				shadow_now = shadow_now + 32'd1;
			end
			pmt_pkg::KIND_ADD: begin
				if (shadow_count >= TABLE_DEPTH) begin
					o.table_full = 1'b1;
				end else begin
					shadow_slots[shadow_count].service = c.service;
					shadow_slots[shadow_count].subtype = c.subtype;
					shadow_slots[shadow_count].request = c.request_id;
					shadow_slots[shadow_count].stamp   = shadow_now;
					shadow_count++;
				end
			end
			pmt_pkg::KIND_FIND, pmt_pkg::KIND_FIND_SINCE: begin
				for (k = 0; k < shadow_count; k++)
					if (hit < 0 && entry_matches(shadow_slots[k], c) &&
						!(c.kind == pmt_pkg::KIND_FIND_SINCE &&
						shadow_slots[k].stamp < c.since_time))
						hit = k;
				if (hit >= 0) begin
					o.found         = 1'b1;
					o.match_service = shadow_slots[hit].service;
					o.match_subtype = shadow_slots[hit].subtype;
					o.match_request = shadow_slots[hit].request;
					drop_entry(hit);
				end
			end
			pmt_pkg::KIND_PURGE: begin
				k = 0;
				while (k < shadow_count) begin
					if (shadow_now - shadow_slots[k].stamp >= c.age_limit) begin
						drop_entry(k);
						o.removed_count = o.removed_count + 7'd1;
					end else begin
						k++;
					end
				end
			end
			default: ;
		endcase
		return o;
	endfunction

	function automatic pmt_pkg::in_t make_cmd(input logic [2:0] kind, input logic [15:0] svc,
		input logic [15:0] sub, input logic [31:0] req, input logic [31:0] since,
		input logic [31:0] limit);
		pmt_pkg::in_t c;
		c.kind       = kind;
		c.service    = svc;
		c.subtype    = sub;
		c.request_id = req;
		c.since_time = since;
		c.age_limit  = limit;
		return c;
	endfunction

	// Random command; finds mostly aim at entries actually in the table
	function automatic pmt_pkg::in_t random_cmd();
		pmt_pkg::in_t    c;
		pmt_pkg::entry_t e;
		int              roll;
		roll = $urandom_range(0, 99);
		if (roll < 12)
			c.kind = pmt_pkg::KIND_TICK;
		else if (roll < 50)
			c.kind = pmt_pkg::KIND_ADD;
		else if (roll < 72)
			c.kind = pmt_pkg::KIND_FIND;
		else if (roll < 86)
			c.kind = pmt_pkg::KIND_FIND_SINCE;
		else if (roll < 96)
			c.kind = pmt_pkg::KIND_PURGE;
		else
			c.kind = 3'($urandom_range(pmt_pkg::KIND_PURGE + 1, KIND_LAST));
		c.service = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		c.subtype = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 3));
		c.request_id = ($urandom_range(0, 3) == 0) ? $urandom : 32'($urandom_range(0, 7));
		case ($urandom_range(0, 4))
			0:       c.since_time = '0;
			1:       c.since_time = $urandom;
			default: c.since_time = shadow_now - 32'($urandom_range(0, 4));
		endcase
		case ($urandom_range(0, 5))
			0:       c.age_limit = '0;
			1:       c.age_limit = $urandom;
			default: c.age_limit = 32'($urandom_range(1, 6));
		endcase
		if ((c.kind == pmt_pkg::KIND_FIND || c.kind == pmt_pkg::KIND_FIND_SINCE) &&
			shadow_count > 0 && $urandom_range(0, 9) < 7) begin
			e = shadow_slots[$urandom_range(0, shadow_count - 1)];
			if (e.service != 16'd0)
				c.service = e.service;
			c.subtype    = $urandom_range(0, 1) ? e.subtype : 16'd0;
			c.request_id = $urandom_range(0, 1) ? e.request : 32'd0;
			if (c.kind == pmt_pkg::KIND_FIND_SINCE && $urandom_range(0, 1))
				c.since_time = e.stamp;
		end
		return c;
	endfunction

	// Send one command beat; predict its result when it is taken
	task automatic send_cmd(input pmt_pkg::in_t c);
		int gap;
		gap = sender_idles ? $urandom_range(0, 8) : 0;
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		cmd   <= c;
		do @(posedge clk); while (busy);
		pending_results.insert(pending_results.size(), table_outcome(c));
	endtask

	// Hold off the sender until every outstanding result is back
	task automatic wait_results_in();
		start <= 1'b0;
		do @(posedge clk); while (pending_results.size() != 0);
	endtask

	task automatic report_field(input string name, input logic [31:0] want,
		input logic [31:0] got);
		if (got !== want) begin
			$display("%0t ns: %s mismatch, expected %h, actual %h", $time, name, want, got);
			mismatches++;
		end
	endtask

	// Result checker: every done beat against the oldest expectation
	always @(posedge clk) begin
		pmt_pkg::out_t want;
		if (done) begin
			if (pending_results.size() == 0) begin
				$display("%0t ns: result with none expected, expected none, actual %h",
					$time, result);
				mismatches++;
			end else begin
				want = pending_results.pop_front();
				report_field("found", 32'(want.found), 32'(result.found));
				report_field("match_service", 32'(want.match_service),
					32'(result.match_service));
				report_field("match_subtype", 32'(want.match_subtype),
					32'(result.match_subtype));
				report_field("match_request", want.match_request, result.match_request);
				report_field("removed_count", 32'(want.removed_count),
					32'(result.removed_count));
				report_field("table_full", 32'(want.table_full), 32'(result.table_full));
			end
		end
	end

	// Ticks and the reserved kinds, which change nothing
	task automatic test_tick_and_spare_kinds();
		send_cmd(make_cmd(pmt_pkg::KIND_TICK, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_PURGE + 3'd1, '1, '1, '1, '1, '1));
		for (int k = pmt_pkg::KIND_PURGE + 2; k <= KIND_LAST; k++)
			send_cmd(make_cmd(3'(k), 16'($urandom), 16'($urandom), $urandom, $urandom,
				$urandom));
		send_cmd(make_cmd(pmt_pkg::KIND_TICK, '1, '1, '1, '1, '1));
	endtask

	// Add and find: wildcards, stored service 0, no match, empty table
	task automatic test_add_and_find();
		send_cmd(make_cmd(pmt_pkg::KIND_FIND, 16'd1, '0, '0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, '1, '1, '1, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'd0, 16'd1, 32'd2, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'd5, 16'd0, 32'd0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND, 16'd9, 16'd3, 32'd3, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND, 16'd7, 16'd0, 32'd0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND, '1, '1, '1, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND, 16'd5, 16'd0, 32'd0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND, 16'd5, 16'd0, 32'd0, '0, '0));
	endtask

	// Find-since skips older stamps; since compared unsigned
	task automatic test_find_since();
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'd3, 16'd4, 32'd5, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_TICK, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_TICK, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'd3, 16'd4, 32'd5, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND_SINCE, 16'd3, 16'd4, 32'd5, shadow_now, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND_SINCE, 16'd3, 16'd0, 32'd0, '1, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND_SINCE, 16'd3, 16'd0, 32'd0, '0, '0));
	endtask

	// Purge by age: huge limit, limit 1, zero limit, empty table
	task automatic test_purge();
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'd1, 16'd1, 32'd1, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_TICK, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'd2, 16'd2, 32'd2, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_PURGE, '0, '0, '0, '0, '1));
		send_cmd(make_cmd(pmt_pkg::KIND_PURGE, '0, '0, '0, '0, 32'd1));
		send_cmd(make_cmd(pmt_pkg::KIND_PURGE, '0, '0, '0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_PURGE, '0, '0, '0, '0, '0));
	endtask

	// Fill to capacity, refuse adds, free one, refill, purge all
	task automatic test_table_full();
		int n;
		n = 0;
		while (shadow_count < TABLE_DEPTH) begin
			if (n % 8 == 7)
				send_cmd(make_cmd(pmt_pkg::KIND_TICK, '0, '0, '0, '0, '0));
			else
				send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'($urandom), 16'($urandom), $urandom,
					'0, '0));
			n++;
		end
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'($urandom), 16'($urandom), $urandom, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, '1, '1, '1, '1, '1));
		send_cmd(make_cmd(pmt_pkg::KIND_FIND_SINCE, shadow_slots[TABLE_DEPTH - 1].service,
			'0, '0, shadow_now, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'd0, 16'd0, 32'd0, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_ADD, 16'd1, 16'd1, 32'd1, '0, '0));
		send_cmd(make_cmd(pmt_pkg::KIND_PURGE, '0, '0, '0, '0, '0));
	endtask

	// Random mix; sender idling switched on and off in stretches
	task automatic test_random_mix(input int count);
		for (int i = 0; i < count; i++) begin
			if (i % 60 == 0)
				sender_idles = $urandom_range(0, 1);
			if (i % 150 == 149)
				wait_results_in();
			send_cmd(random_cmd());
		end
	endtask

	// Test sequence
	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		cmd    = '0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_tick_and_spare_kinds();
		test_add_and_find();
		wait_results_in();
		test_find_since();
		test_purge();
		wait_results_in();
		test_table_full();
		wait_results_in();
		test_random_mix(500);

		wait_results_in();
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
